// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the array unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define OIRA_ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds.
`define OIRA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `OIRA_ASSERT_PROP(label, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/oira_pkg.sv =====
// ----------------------------------------------------------------------------
// oira_pkg
// Shared constants, codes, types and word conversions for the ordered
// insert/remove array.
// ----------------------------------------------------------------------------
`default_nettype none

package oira_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Internal widths follow the capacity and the port widths.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
    localparam int EXT_W = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

    // Read-back reduction: groups of taps ORed per register level.
    localparam int GROUP  = 8;
    localparam int NGROUP = (CAPACITY + GROUP - 1) / GROUP;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                  load;    // overwrite the target cell
        logic                  up;      // insert: target loads, cells above take left
        logic                  down;    // remove: target and above take right
        logic                  rd;      // target drives its word onto the tap
        logic [IDX_W-1:0]      target;
        logic [DATA_WIDTH-1:0] word;
    } t_cell_ctrl;

    function automatic logic [DATA_WIDTH-1:0] to_word(input logic [VALUE_W-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'($signed(v));
        return t[DATA_WIDTH-1:0];
    endfunction

    function automatic logic [VALUE_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
        logic [EXT_W-1:0] t;
        t = EXT_W'($signed(w));
        return t[VALUE_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ordered_insert_remove_array_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_insert_remove_array_unit
// Ordered list of signed words in a chain of cells with an element count.
//
// Request channel (i_valid/o_ready): i_mode, i_position, i_value. Modes are
// append, insert, remove, read and write; unused mode codes do nothing.
// Result channel (o_valid/i_ready): o_read_value (zero unless a successful
// read), o_count after the request, o_status (ok, out of range, full).
// Every request gives exactly one result. One request is in flight at a
// time: after a transfer in, the request passes S_TAP and S_SUM before
// o_valid rises in S_OUT, and o_ready returns the cycle after the result
// transfer. Inserts and removes shift the target cell and all cells above it
// in the accept cycle; the latency comes from the two-level registered OR
// tree that brings the addressed word out to the result.
// While the receiver stalls, the result holds and no request is taken.
// Reset (i_rst_n low, synchronous) empties the list; stored words keep
// their contents but are unreachable until written again.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ordered_insert_remove_array_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [oira_pkg::MODE_W-1:0]     i_mode,
    input  wire logic [oira_pkg::POS_W-1:0]      i_position,
    input  wire logic [oira_pkg::VALUE_W-1:0]    i_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [oira_pkg::VALUE_W-1:0]    o_read_value,
    output logic      [oira_pkg::COUNT_W-1:0]    o_count,
    output logic      [oira_pkg::STATUS_W-1:0]   o_status
);

    typedef enum logic [1:0] {S_IDLE, S_TAP, S_SUM, S_OUT} t_state;

    t_state                             r_state;
    logic [oira_pkg::CNT_W-1:0]         r_count;
    logic [oira_pkg::CNT_W-1:0]         n_count;
    logic [oira_pkg::STATUS_W-1:0]      r_status;
    logic [oira_pkg::STATUS_W-1:0]      n_status;
    logic [oira_pkg::VALUE_W-1:0]       r_read_value;
    logic                               accept;
    logic                               full;
    logic [oira_pkg::CMP_W-1:0]         pos_ext;
    logic [oira_pkg::CMP_W-1:0]         cnt_ext;
    oira_pkg::t_cell_ctrl               ctrl;
    logic [oira_pkg::DATA_WIDTH-1:0]    cell_data [oira_pkg::CAPACITY];
    logic [oira_pkg::DATA_WIDTH-1:0]    cell_tap  [oira_pkg::CAPACITY];
    logic [oira_pkg::DATA_WIDTH-1:0]    tree_word;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign accept  = i_rst_n && i_valid && o_ready;
    assign pos_ext = oira_pkg::CMP_W'(i_position);
    assign cnt_ext = oira_pkg::CMP_W'(r_count);
    assign full    = (r_count == oira_pkg::CNT_W'(oira_pkg::CAPACITY));

    // Decode the request into a chain command and the result status.
    always_comb begin
        ctrl        = '0;
        ctrl.word   = oira_pkg::to_word(i_value);
        ctrl.target = pos_ext[oira_pkg::IDX_W-1:0];
        n_count     = r_count;
        n_status    = oira_pkg::ST_OK;
        case (i_mode)
            oira_pkg::MODE_APPEND: begin
                ctrl.target = cnt_ext[oira_pkg::IDX_W-1:0];
                if (full) begin
                    n_status = oira_pkg::ST_FULL;
                end else begin
                    ctrl.load = accept;
                    n_count   = r_count + oira_pkg::CNT_W'(1);
                end
            end
            oira_pkg::MODE_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    n_status = oira_pkg::ST_RANGE;
                end else if (full) begin
                    n_status = oira_pkg::ST_FULL;
                end else begin
                    ctrl.up = accept;
                    n_count = r_count + oira_pkg::CNT_W'(1);
                end
            end
            oira_pkg::MODE_REMOVE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = oira_pkg::ST_RANGE;
                end else begin
                    ctrl.down = accept;
                    n_count   = r_count - oira_pkg::CNT_W'(1);
                end
            end
            oira_pkg::MODE_READ: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = oira_pkg::ST_RANGE;
                end else begin
                    ctrl.rd = accept;
                end
            end
            oira_pkg::MODE_WRITE: begin
                if (pos_ext >= cnt_ext) begin
                    n_status = oira_pkg::ST_RANGE;
                end else begin
                    ctrl.load = accept;
                end
            end
            default: begin
                n_status = oira_pkg::ST_OK;
            end
        endcase
    end

    for (genvar g = 0; g < oira_pkg::CAPACITY; g++) begin : g_cell
        logic [oira_pkg::DATA_WIDTH-1:0] left_data;
        logic [oira_pkg::DATA_WIDTH-1:0] right_data;

        if (g == 0) begin : g_first
            assign left_data = '0;
        end else begin : g_mid_l
            assign left_data = cell_data[g-1];
        end

        // The top cell keeps its own word when the chain shifts down.
        if (g == oira_pkg::CAPACITY - 1) begin : g_last
            assign right_data = cell_data[g];
        end else begin : g_mid_r
            assign right_data = cell_data[g+1];
        end

        oira_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (ctrl),
            .i_index (oira_pkg::IDX_W'(g)),
            .i_left  (left_data),
            .i_right (right_data),
            .o_data  (cell_data[g]),
            .o_tap   (cell_tap[g])
        );
    end

    oira_read_tree u_read_tree (
        .i_clk  (i_clk),
        .i_taps (cell_tap),
        .o_word (tree_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state  <= S_TAP;
                        r_count  <= n_count;
                        r_status <= n_status;
                    end
                end
                S_TAP: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state      <= S_OUT;
                    r_read_value <= oira_pkg::from_word(tree_word);
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_read_value = r_read_value;
    assign o_count      = oira_pkg::COUNT_W'(r_count);
    assign o_status     = r_status;

    `OIRA_ASSERT_PROP(a_count_bound, i_clk, i_rst_n, r_count <= oira_pkg::CNT_W'(oira_pkg::CAPACITY), "element count above capacity")
    `OIRA_ASSERT_PROP(a_count_hold, i_clk, i_rst_n, !accept |=> $stable(r_count), "element count changed without a transfer")
    `OIRA_ASSERT_NEVER(a_one_in_flight, i_clk, i_rst_n, o_valid && o_ready, "request taken while a result is pending")
    `OIRA_ASSERT_PROP(a_full_status, i_clk, i_rst_n, (o_valid && o_status == oira_pkg::ST_FULL) |-> full, "full status reported with room left")

endmodule

`default_nettype wire

// ===== hdl/oira_cell.sv =====
// ----------------------------------------------------------------------------
// oira_cell
// One element of the list: holds a word, takes it from the request or from
// a neighbor, and drives it onto its read tap when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module oira_cell (
    input  wire logic                            i_clk,
    input  wire oira_pkg::t_cell_ctrl            i_ctrl,
    input  wire logic [oira_pkg::IDX_W-1:0]      i_index,
    input  wire logic [oira_pkg::DATA_WIDTH-1:0] i_left,
    input  wire logic [oira_pkg::DATA_WIDTH-1:0] i_right,
    output logic      [oira_pkg::DATA_WIDTH-1:0] o_data,
    output logic      [oira_pkg::DATA_WIDTH-1:0] o_tap
);

    logic [oira_pkg::DATA_WIDTH-1:0] r_data;
    logic [oira_pkg::DATA_WIDTH-1:0] n_data;
    logic [oira_pkg::DATA_WIDTH-1:0] r_tap;
    logic [oira_pkg::DATA_WIDTH-1:0] n_tap;
    logic                            hit;
    logic                            above;

    assign hit   = (i_index == i_ctrl.target);
    assign above = (i_index > i_ctrl.target);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.load && hit) begin
            n_data = i_ctrl.word;
        end else if (i_ctrl.up) begin
            if (hit) begin
                n_data = i_ctrl.word;
            end else if (above) begin
                n_data = i_left;
            end
        end else if (i_ctrl.down && (hit || above)) begin
            n_data = i_right;
        end
        n_tap = (i_ctrl.rd && hit) ? r_data : '0;
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_tap  <= n_tap;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

`default_nettype wire

// ===== hdl/oira_read_tree.sv =====
// ----------------------------------------------------------------------------
// oira_read_tree
// Registered OR reduction of the cell taps; only the addressed cell drives
// a nonzero tap, so the result is the word read.
// ----------------------------------------------------------------------------
`default_nettype none

module oira_read_tree (
    input  wire logic                            i_clk,
    input  wire logic [oira_pkg::DATA_WIDTH-1:0] i_taps [oira_pkg::CAPACITY],
    output logic      [oira_pkg::DATA_WIDTH-1:0] o_word
);

    logic [oira_pkg::DATA_WIDTH-1:0] r_group [oira_pkg::NGROUP];
    logic [oira_pkg::DATA_WIDTH-1:0] n_group [oira_pkg::NGROUP];

    always_comb begin
        for (int g = 0; g < oira_pkg::NGROUP; g++) begin
            n_group[g] = '0;
            for (int k = 0; k < oira_pkg::GROUP; k++) begin
                if (g * oira_pkg::GROUP + k < oira_pkg::CAPACITY) begin
                    n_group[g] = n_group[g] | i_taps[g * oira_pkg::GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_group <= n_group;
    end

    always_comb begin
        o_word = '0;
        for (int g = 0; g < oira_pkg::NGROUP; g++) begin
            o_word = o_word | r_group[g];
        end
    end

endmodule

`default_nettype wire

// ===== tb/ordered_insert_remove_array_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_insert_remove_array_unit_tb
// Drives append, insert, remove, read and write requests into the ordered
// array unit and checks every result against a list model kept in the bench.
// Covers the empty and full list, every refusal, unused mode codes, extreme
// words and long random traffic that sweeps the list between empty and full,
// with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------

module ordered_insert_remove_array_unit_tb;

    localparam int CAPACITY   = oira_pkg::CAPACITY;
    localparam int DATA_WIDTH = oira_pkg::DATA_WIDTH;
    localparam int MODE_W     = oira_pkg::MODE_W;
    localparam int POS_W      = oira_pkg::POS_W;
    localparam int VALUE_W    = oira_pkg::VALUE_W;
    localparam int COUNT_W    = oira_pkg::COUNT_W;
    localparam int STATUS_W   = oira_pkg::STATUS_W;

    localparam logic [MODE_W-1:0] MODE_APPEND = oira_pkg::MODE_APPEND;
    localparam logic [MODE_W-1:0] MODE_INSERT = oira_pkg::MODE_INSERT;
    localparam logic [MODE_W-1:0] MODE_REMOVE = oira_pkg::MODE_REMOVE;
    localparam logic [MODE_W-1:0] MODE_READ   = oira_pkg::MODE_READ;
    localparam logic [MODE_W-1:0] MODE_WRITE  = oira_pkg::MODE_WRITE;

    localparam logic [STATUS_W-1:0] ST_OK    = oira_pkg::ST_OK;
    localparam logic [STATUS_W-1:0] ST_RANGE = oira_pkg::ST_RANGE;
    localparam logic [STATUS_W-1:0] ST_FULL  = oira_pkg::ST_FULL;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [COUNT_W-1:0]  count;
        logic [STATUS_W-1:0] status;
    } t_list_result;

    localparam logic [MODE_W-1:0] MODE_LAST = '1;
    localparam logic [POS_W-1:0]  POS_MAX   = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [MODE_W-1:0]   i_mode;
    logic [POS_W-1:0]    i_position;
    logic [VALUE_W-1:0]  i_value;
    logic                o_valid;
    logic                i_ready;
    logic [VALUE_W-1:0]  o_read_value;
    logic [COUNT_W-1:0]  o_count;
    logic [STATUS_W-1:0] o_status;

    // List model
    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int                    list_len = 0;
    t_list_result          expected_results [$];

    int mismatches      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int full_refusals   = 0;
    int range_refusals  = 0;
    int peak_len        = 0;
    int sweeps_to_full  = 0;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int burst_left = 0;

    ordered_insert_remove_array_unit i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_mode       (i_mode),
        .i_position   (i_position),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("ordered_insert_remove_array_unit_tb failed");
        $finish;
    end

    // Apply one request to the list model and return the result it gives.
    function automatic t_list_result apply_request(input logic [MODE_W-1:0]  mode,
                                                   input logic [POS_W-1:0]   pos,
                                                   input logic [VALUE_W-1:0] value);
        t_list_result r;
        int           p;
        int           j;
        r.read_value = '0;
        r.status     = ST_OK;
        p            = int'(pos);
        case (mode)
            MODE_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_words[list_len] = value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            MODE_INSERT: begin
                // position check wins over the full check
                if (p > list_len) begin
                    r.status = ST_RANGE;
                end else if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (j = list_len; j > p; j--)
                        list_words[j] = list_words[j-1];
                    list_words[p] = value[DATA_WIDTH-1:0];
                    list_len++;
                end
            end
            MODE_REMOVE: begin
                if (p >= list_len) begin
                    r.status = ST_RANGE;
                end else begin
                    for (j = p; j + 1 < list_len; j++)
                        list_words[j] = list_words[j+1];
                    list_len--;
                end
            end
            MODE_READ: begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    r.read_value = VALUE_W'($signed(list_words[p]));
            end
            MODE_WRITE: begin
                if (p >= list_len)
                    r.status = ST_RANGE;
                else
                    list_words[p] = value[DATA_WIDTH-1:0];
            end
            default: ;
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Predict on request transfers, check on result transfers; predict first
    // so a same-cycle result still finds its expectation.
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                want = apply_request(i_mode, i_position, i_value);
                expected_results.push_back(want);
                requests_sent++;
                if (want.status == ST_FULL)
                    full_refusals++;
                else if (want.status == ST_RANGE)
                    range_refusals++;
                if (list_len > peak_len)
                    peak_len = list_len;
            end
            if (o_valid && i_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result at %0t: read_value %h count %0d status %0d",
                                 $time, o_read_value, o_count, o_status);
                end else begin
                    want = expected_results.pop_front();
                    if (o_read_value !== want.read_value || o_count !== want.count ||
                        o_status !== want.status) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: read_value %h/%h count %0d/%0d %s %0d/%0d",
                                     $time, want.read_value, o_read_value, want.count,
                                     o_count, "status (expected/actual)", want.status,
                                     o_status);
                    end
                end
            end
        end
    end

    // Receiver stalls follow a 16-bit stall pattern that is redrawn each window.
    initial begin : ready_pattern
        logic [15:0] stall_bits;
        int          phase;
        stall_bits = '0;
        phase      = 0;
        i_ready    = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_bits = '0;
                    1:       stall_bits = 16'($urandom) & 16'($urandom);
                    2:       stall_bits = 16'($urandom);
                    default: stall_bits = 16'($urandom) | 16'($urandom);
                endcase
                if (!rx_idle_en)
                    stall_bits = '0;
            end
            i_ready = !stall_bits[phase];
            phase   = (phase + 1) % 16;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer
    // with valid still high, so back-to-back requests keep it asserted.
    task automatic send_request(input logic [MODE_W-1:0]  mode,
                                input logic [POS_W-1:0]   pos,
                                input logic [VALUE_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (!tx_idle_en || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_mode     = mode;
        i_position = pos;
        i_value    = value;
        i_valid    = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic test_empty_list();
        int m;
        send_request(MODE_READ, '0, pick_word());
        send_request(MODE_REMOVE, '0, pick_word());
        send_request(MODE_WRITE, '0, pick_word());
        send_request(MODE_INSERT, POS_W'(1), pick_word());
        for (m = int'(MODE_WRITE) + 1; m <= int'(MODE_LAST); m++)
            send_request(MODE_W'(m), POS_MAX, 32'($urandom));
    endtask

    task automatic test_edge_values();
        int k;
        send_request(MODE_APPEND, POS_MAX, 32'h8000_0000);
        send_request(MODE_APPEND, '0, 32'h7FFF_FFFF);
        send_request(MODE_INSERT, '0, 32'hFFFF_FFFF);
        // insert at the count acts as append
        send_request(MODE_INSERT, POS_W'(list_len), 32'h0000_0000);
        send_request(MODE_INSERT, POS_W'(2), 32'h5555_5555);
        for (k = 0; k < 5; k++)
            send_request(MODE_READ, POS_W'(k), pick_word());
        send_request(MODE_WRITE, POS_W'(4), 32'hAAAA_AAAA);
        send_request(MODE_READ, POS_W'(4), '0);
        send_request(MODE_READ, POS_W'(5), '0);
        send_request(MODE_WRITE, POS_MAX, 32'($urandom));
        send_request(MODE_REMOVE, POS_W'(5), '0);
        send_request(MODE_REMOVE, POS_W'(4), '0);
        send_request(MODE_REMOVE, '0, '0);
        send_request(MODE_REMOVE, POS_W'(1), '0);
        send_request(MODE_READ, '0, '0);
        send_request(MODE_READ, POS_W'(1), '0);
    endtask

    task automatic test_full_store();
        tx_idle_en = 1'b0;
        while (list_len < CAPACITY) begin
            if ($urandom_range(0, 1) == 0)
                send_request(MODE_APPEND, POS_W'($urandom), pick_word());
            else
                send_request(MODE_INSERT, POS_W'($urandom_range(0, list_len)), pick_word());
        end
        tx_idle_en = 1'b1;
        send_request(MODE_APPEND, '0, pick_word());
        send_request(MODE_INSERT, '0, pick_word());
        send_request(MODE_INSERT, POS_W'(CAPACITY), pick_word());
        send_request(MODE_INSERT, POS_W'(CAPACITY + 1), pick_word());
        send_request(MODE_READ, POS_W'(CAPACITY - 1), '0);
        send_request(MODE_READ, POS_W'(CAPACITY), '0);
        send_request(MODE_WRITE, POS_W'(CAPACITY - 1), pick_word());
        send_request(MODE_REMOVE, POS_W'(CAPACITY - 1), '0);
        send_request(MODE_INSERT, POS_W'(list_len), pick_word());
        send_request(MODE_APPEND, '0, pick_word());
        // drain with scattered removes and reads
        while (list_len > 0) begin
            if ($urandom_range(0, 3) == 0)
                send_request(MODE_READ, POS_W'($urandom_range(0, list_len - 1)), pick_word());
            else
                send_request(MODE_REMOVE, POS_W'($urandom_range(0, list_len - 1)), pick_word());
        end
    endtask

    task automatic test_random_traffic(input int n_items);
        int                 done;
        int                 sel;
        int                 w;
        bit                 grow;
        logic [MODE_W-1:0]  mode;
        logic [POS_W-1:0]   pos;
        done = 0;
        grow = 1'b1;
        while (done < n_items) begin
            if (done % 60 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (list_len == CAPACITY) begin
                if (grow)
                    sweeps_to_full++;
                grow = 1'b0;
            end else if (list_len == 0) begin
                grow = 1'b1;
            end else if ($urandom_range(0, 99) == 0) begin
                grow = !grow;
            end
            sel = $urandom_range(0, 99);
            if (sel < 3) begin
                mode = MODE_W'($urandom_range(int'(MODE_WRITE) + 1, int'(MODE_LAST)));
                pos  = POS_W'($urandom);
            end else if (sel < 9) begin
                mode = MODE_W'($urandom_range(int'(MODE_APPEND), int'(MODE_WRITE)));
                pos  = POS_W'($urandom);
            end else begin
                w = $urandom_range(0, 99);
                if (grow)
                    mode = (w < 25) ? MODE_APPEND : (w < 55) ? MODE_INSERT :
                           (w < 65) ? MODE_REMOVE : (w < 85) ? MODE_READ : MODE_WRITE;
                else
                    mode = (w < 5) ? MODE_APPEND : (w < 15) ? MODE_INSERT :
                           (w < 60) ? MODE_REMOVE : (w < 85) ? MODE_READ : MODE_WRITE;
                if (mode == MODE_INSERT)
                    pos = POS_W'($urandom_range(0, list_len));
                else if (list_len > 0)
                    pos = POS_W'($urandom_range(0, list_len - 1));
                else
                    pos = '0;
            end
            send_request(mode, pos, pick_word());
            if (mode <= MODE_WRITE)
                done++;
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_mode     = MODE_APPEND;
        i_position = '0;
        i_value    = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_list();
        test_edge_values();
        test_full_store();
        test_random_traffic(700);
        i_valid = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, mismatches);
        $display("%0d full and %0d out-of-range refusals, peak length %0d, %0d random fills",
                 full_refusals, range_refusals, peak_len, sweeps_to_full);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("ordered_insert_remove_array_unit_tb passed");
        else
            $display("ordered_insert_remove_array_unit_tb failed");
        $finish;
    end

endmodule
